### rtl/core/bgrg_pkg.sv
// bgrg_pkg: shared constants and types for the bgr24 to gray8 row stream core
// no dependencies; imported by the core, gray_row_checker and the testbench
`default_nettype none

package bgrg_pkg;

    // default size register width
    localparam int DIM_BITS_DEFAULT = 12;

    // luma weights, scaled by 1000
    localparam int unsigned COEF_R = 299;
    localparam int unsigned COEF_G = 587;
    localparam int unsigned COEF_B = 114;

    // weighted sum width: 255 * 1000 fits in 18 bits
    localparam int SUM_BITS = 18;

    // divide by 1000 as (sum >> 3) / 125, the latter as multiply and shift
    localparam int DIV_PRE_SHIFT = 3;
    localparam int DIV_IN_BITS   = SUM_BITS - DIV_PRE_SHIFT;
    localparam int RECIP_BITS    = 16;
    localparam int RECIP_SHIFT   = 22;
    localparam logic [RECIP_BITS-1:0] RECIP_125 = 16'd33555;
    localparam int PROD_BITS     = DIV_IN_BITS + RECIP_BITS;

    // configuration register codes, taken from paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // row bookkeeping that travels with a pixel down the pipeline
    typedef struct packed {
        logic       row_end;
        logic       img_end;
        logic [1:0] pad_cnt;
    } run_info_t;

endpackage

`default_nettype wire

### rtl/core/bgr24_to_gray8_row_stream_core.sv
// bgr24_to_gray8_row_stream_core: bmp bgr24 pixel bytes in, gray8 row bytes out
// depends on bgrg_pkg
`default_nettype none

// Takes one source byte per transfer (blue, green, red, then source row padding)
// and returns one gray byte (299R + 587G + 114B) / 1000, rounded down, for each
// red byte. At the end of a row the gray byte is followed by zero to three zero
// bytes that pad the output row to a multiple of four bytes; these leave the
// output register one per cycle while result_stall is low, and while they do the
// pipeline behind it holds. A three-deep pipeline (pixel register, weighted sum
// register, result register) sits between the two sides, so a byte can be taken
// in every cycle, and data_stall rises only when all three hold work and the
// result register cannot empty in this cycle: result_stall is high, or padding
// bytes still follow the byte it holds. data_stall follows result_stall
// combinationally.
// image_width and image_height are to be written over the APB port only while
// the block is idle; the block itself does not enforce this. A value of zero
// acts as one.
module bgr24_to_gray8_row_stream_core
    import bgrg_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // source byte channel
    input  wire logic        data_valid,
    output logic             data_stall,
    input  wire logic [7:0]  data_byte,
    // result channel
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic      [7:0]  out_byte,
    output logic             is_padding,
    output logic             last_of_run,
    output logic             row_done,
    output logic             image_done
);

    typedef enum logic [1:0] {
        PH_BLUE  = 2'd0,
        PH_GREEN = 2'd1,
        PH_RED   = 2'd2,
        PH_SKIP  = 2'd3
    } phase_t;

    // configuration registers
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;
    logic                cfg_write;

    // byte sequencing state
    phase_t              phase_reg,  phase_next;
    logic [7:0]          blue_reg,   blue_next;
    logic [7:0]          green_reg,  green_next;
    logic [DIM_BITS-1:0] col_reg,    col_next;
    logic [DIM_BITS-1:0] row_reg,    row_next;
    logic [1:0]          skip_reg,   skip_next;

    // pipeline stages
    logic                pix_valid_reg;
    logic [7:0]          pix_r_reg, pix_g_reg, pix_b_reg;
    run_info_t           pix_info_reg;
    logic                sum_valid_reg;
    logic [SUM_BITS-1:0] sum_reg;
    run_info_t           sum_info_reg;
    logic                res_valid_reg;
    logic [7:0]          res_byte_reg;
    logic                res_pad_reg;
    logic [1:0]          pads_left_reg;
    logic                res_row_end_reg;
    logic                res_img_end_reg;

    // handshake and datapath helpers
    logic                out_xfer;
    logic                out_free;
    logic                sum_adv;
    logic                pix_adv;
    logic                in_xfer;
    logic                take_red;
    logic [DIM_BITS-1:0] w_eff, h_eff;
    logic [DIM_BITS-1:0] col_inc, row_inc;
    logic                row_end, img_end;
    logic [1:0]          dst_pad, src_pad;
    run_info_t           info_new;
    logic [SUM_BITS-1:0] sum_new;
    logic [PROD_BITS-1:0] quot_prod;
    logic [7:0]          gray;

    // configuration writes and reads
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_BITS'(1);
            height_reg <= DIM_BITS'(1);
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[DIM_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[DIM_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_IMAGE_WIDTH:  prdata = 32'(width_reg);
            REG_IMAGE_HEIGHT: prdata = 32'(height_reg);
            default:          prdata = '0;
        endcase
    end

    // pipeline advance chain, from the result side back to the source side
    assign out_xfer   = res_valid_reg && !result_stall;
    assign out_free   = !res_valid_reg || (out_xfer && (pads_left_reg == 2'd0));
    assign sum_adv    = !sum_valid_reg || out_free;
    assign pix_adv    = !pix_valid_reg || sum_adv;
    assign data_stall = !pix_adv;
    assign in_xfer    = data_valid && !data_stall;
    assign take_red   = in_xfer && (phase_reg == PH_RED);

    // row and image bookkeeping for a red byte
    always_comb
    begin
        w_eff    = (width_reg  == '0) ? DIM_BITS'(1) : width_reg;
        h_eff    = (height_reg == '0) ? DIM_BITS'(1) : height_reg;
        col_inc  = col_reg + DIM_BITS'(1);
        row_inc  = row_reg + DIM_BITS'(1);
        row_end  = (col_inc == '0) || (col_inc >= w_eff);
        img_end  = (row_inc == '0) || (row_inc >= h_eff);
        // output pads to -w mod 4, source pads to -3w mod 4 which is w mod 4
        dst_pad  = 2'(~w_eff[1:0] + 2'd1);
        src_pad  = w_eff[1:0];
        info_new.row_end = row_end;
        info_new.img_end = row_end && img_end;
        info_new.pad_cnt = row_end ? dst_pad : 2'd0;
    end

    // byte phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        blue_next  = blue_reg;
        green_next = green_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        skip_next  = skip_reg;
        if (in_xfer)
        begin
            unique case (phase_reg)
                PH_BLUE:
                begin
                    blue_next  = data_byte;
                    phase_next = PH_GREEN;
                end
                PH_GREEN:
                begin
                    green_next = data_byte;
                    phase_next = PH_RED;
                end
                PH_RED:
                begin
                    phase_next = PH_BLUE;
                    col_next   = col_inc;
                    if (row_end)
                    begin
                        col_next = '0;
                        row_next = img_end ? '0 : row_inc;
                        if (src_pad != 2'd0)
                        begin
                            skip_next  = src_pad;
                            phase_next = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 2'd1;
                    if (skip_reg == 2'd1)
                        phase_next = PH_BLUE;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_BLUE;
            blue_reg  <= '0;
            green_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
            skip_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            blue_reg  <= blue_next;
            green_reg <= green_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            skip_reg  <= skip_next;
        end
    end

    // weighted sum and divide by 1000
    assign sum_new = SUM_BITS'(pix_r_reg) * SUM_BITS'(COEF_R)
                   + SUM_BITS'(pix_g_reg) * SUM_BITS'(COEF_G)
                   + SUM_BITS'(pix_b_reg) * SUM_BITS'(COEF_B);
    assign quot_prod = PROD_BITS'(sum_reg[SUM_BITS-1:DIV_PRE_SHIFT])
                     * PROD_BITS'(RECIP_125);
    assign gray = quot_prod[RECIP_SHIFT +: 8];

    // stage valids and run counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            sum_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            pads_left_reg <= '0;
        end
        else
        begin
            if (pix_adv)
                pix_valid_reg <= take_red;
            if (sum_adv)
                sum_valid_reg <= pix_valid_reg;
            if (out_free)
            begin
                res_valid_reg <= sum_valid_reg;
                pads_left_reg <= sum_valid_reg ? sum_info_reg.pad_cnt : 2'd0;
            end
            else if (out_xfer)
                pads_left_reg <= pads_left_reg - 2'd1;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (take_red)
        begin
            pix_r_reg    <= data_byte;
            pix_g_reg    <= green_reg;
            pix_b_reg    <= blue_reg;
            pix_info_reg <= info_new;
        end
        if (sum_adv && pix_valid_reg)
        begin
            sum_reg      <= sum_new;
            sum_info_reg <= pix_info_reg;
        end
        if (out_free && sum_valid_reg)
        begin
            res_byte_reg    <= gray;
            res_pad_reg     <= 1'b0;
            res_row_end_reg <= sum_info_reg.row_end;
            res_img_end_reg <= sum_info_reg.img_end;
        end
        else if (!out_free && out_xfer)
        begin
            res_byte_reg <= 8'd0;
            res_pad_reg  <= 1'b1;
        end
    end

    // result port
    assign result_valid = res_valid_reg;
    assign out_byte     = res_byte_reg;
    assign is_padding   = res_pad_reg;
    assign last_of_run  = (pads_left_reg == 2'd0);
    assign row_done     = last_of_run && res_row_end_reg;
    assign image_done   = last_of_run && res_img_end_reg;

    // checks
    a_pad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && is_padding) |-> (out_byte == 8'd0))
        else $error("padding byte is not zero");

    a_image_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && image_done) |-> (row_done && last_of_run))
        else $error("image end without row end");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && !last_of_run) |=> (result_valid && is_padding))
        else $error("run cut short before its padding");

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        data_stall |-> (pix_valid_reg && sum_valid_reg && res_valid_reg))
        else $error("source stalled with room in the pipeline");

endmodule

`default_nettype wire

### tb/gray_row_checker.sv
// gray_row_checker: watches the byte channels and the apb port of the gray row core
// predicts each gray and padding result and compares it with what the core sends
// depends on bgrg_pkg
`default_nettype none

module gray_row_checker
    import bgrg_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    input  wire logic        data_valid,
    input  wire logic        data_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        result_valid,
    input  wire logic        result_stall,
    input  wire logic [7:0]  out_byte,
    input  wire logic        is_padding,
    input  wire logic        last_of_run,
    input  wire logic        row_done,
    input  wire logic        image_done,
    output int               fails,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        SLOT_BLUE  = 2'd0,
        SLOT_GREEN = 2'd1,
        SLOT_RED   = 2'd2,
        SLOT_SKIP  = 2'd3
    } byte_slot_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_padding;
        logic       last_of_run;
        logic       row_done;
        logic       image_done;
    } gray_result_t;

    // predicted results not yet seen on the result channel
    gray_result_t gray_expect_q[$];

    // shadow of the size registers and of the row state
    logic [DIM_BITS-1:0] width_reg;
    logic [DIM_BITS-1:0] height_reg;
    byte_slot_t          slot;
    logic [7:0]          blue_byte;
    logic [7:0]          green_byte;
    logic [DIM_BITS-1:0] col_cnt;
    logic [DIM_BITS-1:0] row_cnt;
    logic [1:0]          skip_left;
    int                  results_seen;

    task automatic report_mismatch(input string what);
        $display("gray_row_checker: %s", what);
        fails++;
    endtask

    // red byte completes a pixel: gray byte, then output row padding at row end
    task automatic predict_pixel(input logic [7:0] red);
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
        int unsigned         sum;
        logic [7:0]          gray;
        logic [1:0]          dst_pad;
        logic [1:0]          src_pad;
        logic                img_end;
        int                  n;
        gray_result_t        r;
        w = (width_reg == '0) ? DIM_BITS'(1) : width_reg;
        h = (height_reg == '0) ? DIM_BITS'(1) : height_reg;
        sum = 299 * red + 587 * green_byte + 114 * blue_byte;
        gray = 8'(sum / 1000);
        col_cnt = col_cnt + 1'b1;
        slot = SLOT_BLUE;
        if (col_cnt != '0 && col_cnt < w)
        begin
            r = '{gray, 1'b0, 1'b1, 1'b0, 1'b0};
            gray_expect_q.push_back(r);
        end
        else
        begin
            // pad output row to a multiple of 4; source pad of 3w bytes is w mod 4
            dst_pad = 2'(3'd4 - {1'b0, w[1:0]});
            src_pad = w[1:0];
            row_cnt = row_cnt + 1'b1;
            img_end = (row_cnt == '0 || row_cnt >= h);
            n = 1 + dst_pad;
            for (int k = 0; k < n; k++)
            begin
                r.out_byte    = (k == 0) ? gray : 8'd0;
                r.is_padding  = (k != 0);
                r.last_of_run = (k == n - 1);
                r.row_done    = (k == n - 1);
                r.image_done  = (k == n - 1) && img_end;
                gray_expect_q.push_back(r);
            end
            if (img_end)
                row_cnt = '0;
            col_cnt = '0;
            if (src_pad != 2'd0)
            begin
                skip_left = src_pad;
                slot = SLOT_SKIP;
            end
        end
    endtask

    // one accepted source byte
    task automatic predict_byte(input logic [7:0] b);
        case (slot)
            SLOT_BLUE:
            begin
                blue_byte = b;
                slot = SLOT_GREEN;
            end
            SLOT_GREEN:
            begin
                green_byte = b;
                slot = SLOT_RED;
            end
            SLOT_SKIP:
            begin
                skip_left = skip_left - 1'b1;
                if (skip_left == 2'd0)
                    slot = SLOT_BLUE;
            end
            default:
                predict_pixel(b);
        endcase
    endtask

    // one accepted result against the oldest prediction
    task automatic check_result();
        gray_result_t got;
        gray_result_t want;
        got = '{out_byte, is_padding, last_of_run, row_done, image_done};
        results_seen++;
        if (gray_expect_q.size() == 0)
        begin
            report_mismatch($sformatf(
                "result %0d unexpected: byte %0d pad %0b last %0b row %0b img %0b",
                results_seen, got.out_byte, got.is_padding, got.last_of_run,
                got.row_done, got.image_done));
        end
        else
        begin
            want = gray_expect_q.pop_front();
            if (got != want)
                report_mismatch($sformatf({"result %0d: got byte %0d pad %0b last %0b",
                    " row %0b img %0b, want %0d %0b %0b %0b %0b"},
                    results_seen, got.out_byte, got.is_padding, got.last_of_run,
                    got.row_done, got.image_done, want.out_byte, want.is_padding,
                    want.last_of_run, want.row_done, want.image_done));
        end
    endtask

    // sample every transfer at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    = DIM_BITS'(1);
            height_reg   = DIM_BITS'(1);
            slot         = SLOT_BLUE;
            blue_byte    = '0;
            green_byte   = '0;
            col_cnt      = '0;
            row_cnt      = '0;
            skip_left    = '0;
            results_seen = 0;
            fails        = 0;
            gray_expect_q.delete();
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_IMAGE_WIDTH)
                    width_reg = pwdata[DIM_BITS-1:0];
                else
                    height_reg = pwdata[DIM_BITS-1:0];
            end
            if (data_valid && !data_stall)
                predict_byte(data_byte);
            if (result_valid && !result_stall)
                check_result();
            pending <= gray_expect_q.size();
        end
    end

endmodule

`default_nettype wire

### tb/tb_bgr24_to_gray8_row_stream_core.sv
// tb_bgr24_to_gray8_row_stream_core: stimulus and verdict for the gray row core
// drives bytes and size writes under several idle and stall patterns
// depends on bgrg_pkg, bgr24_to_gray8_row_stream_core and gray_row_checker
`default_nettype none

module tb_bgr24_to_gray8_row_stream_core;
    import bgrg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLDOFF_LEN   = 60;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SEGMENTS      = 8;
    localparam int SEG_BYTES     = 14;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        data_valid = 1'b0;
    logic        data_stall;
    logic [7:0]  data_byte = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        is_padding;
    logic        last_of_run;
    logic        row_done;
    logic        image_done;

    int fails;
    int pending;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int holdoff_req = 0;
    int holdoff_ack = 0;
    int holdoff_left = 0;
    int quiet_cycles = 0;

    always #1 clk = ~clk;

    bgr24_to_gray8_row_stream_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .data_valid   (data_valid),
        .data_stall   (data_stall),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .is_padding   (is_padding),
        .last_of_run  (last_of_run),
        .row_done     (row_done),
        .image_done   (image_done)
    );

    gray_row_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .data_valid   (data_valid),
        .data_stall   (data_stall),
        .data_byte    (data_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .is_padding   (is_padding),
        .last_of_run  (last_of_run),
        .row_done     (row_done),
        .image_done   (image_done),
        .fails        (fails),
        .pending      (pending)
    );

    // result side: random stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (holdoff_req != holdoff_ack)
        begin
            holdoff_ack  <= holdoff_req;
            holdoff_left <= HOLDOFF_LEN;
            result_stall <= 1'b1;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge clk)
    begin
        if ((data_valid && !data_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // one source byte transfer, after an optional random gap
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            data_valid <= 1'b0;
            @(posedge clk);
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
    endtask

    task automatic send_pixel(input logic [7:0] blue, input logic [7:0] green,
                              input logic [7:0] red);
        send_byte(blue);
        send_byte(green);
        send_byte(red);
    endtask

    // stop offering bytes and let every predicted result come out
    task automatic wait_drained();
        data_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_size(input logic regsel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regsel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // pixel byte with extra weight on the extremes
    function automatic logic [7:0] rand_pixel_byte();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial
    begin
        logic [11:0] w;
        logic [11:0] h;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes: one pixel per row, one row per image
        send_pixel(8'd0, 8'd0, 8'd0);
        send_byte(8'h5A);

        // zero width acts as one, wide height keeps its low bits (three rows)
        wait_drained();
        write_size(REG_IMAGE_WIDTH, 32'd0);
        write_size(REG_IMAGE_HEIGHT, 32'hFFFF_F003);
        send_pixel(8'd255, 8'd0, 8'd0);
        send_byte(8'hFF);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_byte(8'h33);
        send_pixel(8'd0, 8'd0, 8'd255);
        send_byte(8'h00);

        // width shrinks mid-row: next pixel ends the row
        wait_drained();
        write_size(REG_IMAGE_WIDTH, 32'd3);
        write_size(REG_IMAGE_HEIGHT, 32'd1);
        send_pixel(8'd10, 8'd20, 8'd30);
        wait_drained();
        write_size(REG_IMAGE_WIDTH, 32'd1);
        send_pixel(8'd200, 8'd100, 8'd50);
        send_byte(8'h01);

        // random segments: none, source idle, result stall, both
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_drained();
            case (seg / 2)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct <= 0;
                end
                1:
                begin
                    src_idle_pct   = 63;
                    sink_stall_pct <= 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct <= 63;
                end
                default:
                begin
                    src_idle_pct   = 25;
                    sink_stall_pct <= 25;
                end
            endcase
            w = (seg == 2) ? 12'hFFF : 12'($urandom_range(0, 5));
            h = (seg == 6) ? 12'hFFF : 12'($urandom_range(0, 3));
            write_size(REG_IMAGE_WIDTH, {20'($urandom), w});
            write_size(REG_IMAGE_HEIGHT, {20'($urandom), h});
            // long result hold-off while bytes keep coming, so the core backs up
            if (seg == 0)
                holdoff_req <= holdoff_req + 1;
            repeat (SEG_BYTES) send_byte(rand_pixel_byte());
        end

        wait_drained();
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
